// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file blcr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Labeled concurrent assertion, disabled while dis is high.
`define BLCR_ASSERT(lbl, clk, dis, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) prop) else $error(msg);

// Labeled concurrent assertion that is checked in reset too.
`define BLCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/blcr_pkg.sv -----
// Shared types and constants of the line rasterizer.
`default_nettype none
package blcr_pkg;
  localparam int MAX_DIM_DEF    = 2048;
  localparam int COORD_BITS_DEF = 13;
  localparam int COLOR_BITS_DEF = 8;
  localparam int DIM_BITS       = 12;
  localparam int INDEX_BITS     = 22;
  localparam int CFG_IDX_BITS   = 2;
  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic calc;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic line_active;
    logic div_last;
  } sts_t;
endpackage
`default_nettype wire

// ----- hdl/blcr_cfg_if.sv -----
// Configuration write channel.
`default_nettype none
interface blcr_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [blcr_pkg::CFG_IDX_BITS-1:0]   index;
  logic [blcr_pkg::DIM_BITS-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/blcr_pix_in_if.sv -----
// Line request channel.
`default_nettype none
interface blcr_pix_in_if #(
  parameter int COORD_BITS = blcr_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = blcr_pkg::COLOR_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [COLOR_BITS-1:0]        start_red;
  logic [COLOR_BITS-1:0]        start_green;
  logic [COLOR_BITS-1:0]        start_blue;
  logic [COLOR_BITS-1:0]        end_red;
  logic [COLOR_BITS-1:0]        end_green;
  logic [COLOR_BITS-1:0]        end_blue;
  modport source (output valid, func, start_x, start_y, end_x, end_y, start_red,
                  start_green, start_blue, end_red, end_green, end_blue, input ready);
  modport sink (input valid, func, start_x, start_y, end_x, end_y, start_red,
                start_green, start_blue, end_red, end_green, end_blue, output ready);
endinterface
`default_nettype wire

// ----- hdl/blcr_pix_out_if.sv -----
// Pixel result channel.
`default_nettype none
interface blcr_pix_out_if #(
  parameter int COORD_BITS = blcr_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = blcr_pkg::COLOR_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [COORD_BITS-1:0]      pixel_x;
  logic signed [COORD_BITS-1:0]      pixel_y;
  logic [blcr_pkg::INDEX_BITS-1:0]   pixel_index;
  logic                              inside_res;
  logic [COLOR_BITS-1:0]             red;
  logic [COLOR_BITS-1:0]             green;
  logic [COLOR_BITS-1:0]             blue;
  logic                              last;
  modport source (output valid, pixel_x, pixel_y, pixel_index, inside_res, red, green,
                  blue, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_index, inside_res, red, green,
                blue, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/bresenham_line_color_rasterizer.sv -----
// Top level of the Bresenham line rasterizer with color interpolation.
// A request runs through the states CALC, DIV and HOLD, and no new request is
//   accepted until the controller is back in IDLE. The divider is a restoring one
//   that produces one quotient bit per cycle in each of the three color channels.
// A step request with no active line is accepted in IDLE and gives no pixel.
// Reset (synchronous, rst high): no line active, result empty, frame 640 x 480.
`default_nettype none
module bresenham_line_color_rasterizer #(
  parameter int MAX_DIM    = blcr_pkg::MAX_DIM_DEF,
  parameter int COORD_BITS = blcr_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = blcr_pkg::COLOR_BITS_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  blcr_cfg_if.sink      cfg,
  blcr_pix_in_if.sink   pix_in,
  blcr_pix_out_if.source pix_out
);
  blcr_pkg::cmd_t cmd;
  blcr_pkg::sts_t sts;
  logic [3*COLOR_BITS-1:0] rgb;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  // Controller: accept requests, sequence the divider, own the result valid.
  blcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_in.valid),
    .in_func   (pix_in.func),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: line state, clip and index, color divide, result register.
  blcr_datapath #(
    .MAX_DIM    (MAX_DIM),
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .start_x     (pix_in.start_x),
    .start_y     (pix_in.start_y),
    .end_x       (pix_in.end_x),
    .end_y       (pix_in.end_y),
    .start_rgb   ({pix_in.start_blue, pix_in.start_green, pix_in.start_red}),
    .end_rgb     ({pix_in.end_blue, pix_in.end_green, pix_in.end_red}),
    .pixel_x     (pix_out.pixel_x),
    .pixel_y     (pix_out.pixel_y),
    .pixel_index (pix_out.pixel_index),
    .inside_res  (pix_out.inside_res),
    .rgb         (rgb),
    .last        (pix_out.last)
  );

  // Unpack the color lanes: red in the low lane.
  assign pix_out.red   = rgb[0 +: COLOR_BITS];
  assign pix_out.green = rgb[COLOR_BITS +: COLOR_BITS];
  assign pix_out.blue  = rgb[2*COLOR_BITS +: COLOR_BITS];
endmodule
`default_nettype wire

// ----- hdl/blcr_ctrl.sv -----
// Sequencer of the rasterizer: request intake, divide loop, result register.
`default_nettype none
module blcr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_func,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire blcr_pkg::sts_t  sts,
  output blcr_pkg::cmd_t       cmd
);
  blcr_pkg::state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= blcr_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      blcr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func) begin
            cmd.start  = 1'b1;
            state_next = blcr_pkg::S_CALC;
          end else if (sts.line_active) begin
            cmd.step   = 1'b1;
            state_next = blcr_pkg::S_CALC;
          end
        end
      end
      blcr_pkg::S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = blcr_pkg::S_DIV;
      end
      blcr_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = blcr_pkg::S_HOLD;
      end
      blcr_pkg::S_HOLD: begin
        // wait for the result register to free up
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = blcr_pkg::S_IDLE;
        end
      end
      default: state_next = blcr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end
endmodule
`default_nettype wire

// ----- hdl/blcr_datapath.sv -----
// Line stepper, pixel address, color divider and result register.
`default_nettype none
module blcr_datapath #(
  parameter int MAX_DIM    = blcr_pkg::MAX_DIM_DEF,
  parameter int COORD_BITS = blcr_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = blcr_pkg::COLOR_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire blcr_pkg::cmd_t                      cmd,
  output blcr_pkg::sts_t                           sts,
  input  wire logic                                cfg_we,
  input  wire logic [blcr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [blcr_pkg::DIM_BITS-1:0]       cfg_data,
  input  wire logic signed [COORD_BITS-1:0]        start_x,
  input  wire logic signed [COORD_BITS-1:0]        start_y,
  input  wire logic signed [COORD_BITS-1:0]        end_x,
  input  wire logic signed [COORD_BITS-1:0]        end_y,
  input  wire logic [3*COLOR_BITS-1:0]             start_rgb,
  input  wire logic [3*COLOR_BITS-1:0]             end_rgb,
  output logic signed [COORD_BITS-1:0]             pixel_x,
  output logic signed [COORD_BITS-1:0]             pixel_y,
  output logic [blcr_pkg::INDEX_BITS-1:0]          pixel_index,
  output logic                                     inside_res,
  output logic [3*COLOR_BITS-1:0]                  rgb,
  output logic                                     last
);
  localparam int DW     = COORD_BITS + 1;
  localparam int ERR_W  = COORD_BITS + 3;
  localparam int NUM_W  = COLOR_BITS + COORD_BITS;
  localparam int BC_W   = $clog2(COLOR_BITS);
  localparam int EW     = blcr_pkg::DIM_BITS + 1;
  localparam int CMP_W  = (COORD_BITS > EW) ? COORD_BITS : EW;
  localparam int PROD_W = 2 * CMP_W;
  localparam logic [EW-1:0] MAX_DIM_V = EW'(MAX_DIM);

  logic [blcr_pkg::DIM_BITS-1:0] frame_width, frame_height;
  logic                          line_active, major_is_x, minor_down;
  logic signed [COORD_BITS-1:0]  major_pos, minor_pos;
  logic [COORD_BITS-1:0]         step_i, line_len;
  logic signed [ERR_W-1:0]       error_term, inc_no_step, inc_with_step;
  logic [COLOR_BITS-1:0]         color_from [3];
  logic [COLOR_BITS-1:0]         color_to [3];

  logic signed [COORD_BITS-1:0]  calc_x, calc_y;
  logic                          calc_inside, calc_last, sel_from, sel_to;
  logic [blcr_pkg::INDEX_BITS-1:0] calc_index;
  logic [NUM_W-1:0]              rem [3];
  logic [COLOR_BITS-1:0]         quot [3];
  logic [BC_W-1:0]               bit_cnt;

  // start decode
  logic signed [DW-1:0] x0, y0, x1, y1, adx, ady, a0, b0, a1, b1, sa0, sb0, sa1, sb1;
  logic signed [DW-1:0] d_s, e_s, e_abs;
  logic                 mx, swap;
  always_comb begin
    x0  = DW'(start_x);
    y0  = DW'(start_y);
    x1  = DW'(end_x);
    y1  = DW'(end_y);
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    mx  = adx > ady;
    a0  = mx ? x0 : y0;
    b0  = mx ? y0 : x0;
    a1  = mx ? x1 : y1;
    b1  = mx ? y1 : x1;
    swap = a0 > a1;
    sa0 = swap ? a1 : a0;
    sb0 = swap ? b1 : b0;
    sa1 = swap ? a0 : a1;
    sb1 = swap ? b0 : b1;
    d_s = sa1 - sa0;
    e_s = sb1 - sb0;
    e_abs = e_s[DW-1] ? -e_s : e_s;
  end

  logic [COORD_BITS-1:0] step_i_inc;
  assign step_i_inc = step_i + COORD_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= blcr_pkg::WIDTH_RESET;
      frame_height <= blcr_pkg::HEIGHT_RESET;
      line_active  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          blcr_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          blcr_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.start) line_active <= d_s != '0;
      else if (cmd.step) line_active <= step_i_inc < line_len;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      major_is_x    <= mx;
      major_pos     <= COORD_BITS'(sa0);
      minor_pos     <= COORD_BITS'(sb0);
      step_i        <= '0;
      line_len      <= COORD_BITS'(d_s);
      minor_down    <= e_s[DW-1];
      error_term    <= (ERR_W'(e_abs) <<< 1) - ERR_W'(d_s);
      inc_no_step   <= ERR_W'(e_abs) <<< 1;
      inc_with_step <= (ERR_W'(e_abs) <<< 1) - (ERR_W'(d_s) <<< 1);
      for (int k = 0; k < 3; k++) begin
        color_from[k] <= swap ? end_rgb[k*COLOR_BITS +: COLOR_BITS]
                              : start_rgb[k*COLOR_BITS +: COLOR_BITS];
        color_to[k]   <= swap ? start_rgb[k*COLOR_BITS +: COLOR_BITS]
                              : end_rgb[k*COLOR_BITS +: COLOR_BITS];
      end
    end else if (cmd.step) begin
      major_pos <= major_pos + COORD_BITS'(1);
      step_i    <= step_i_inc;
      if (error_term[ERR_W-1]) begin
        error_term <= error_term + inc_no_step;
      end else begin
        error_term <= error_term + inc_with_step;
        minor_pos  <= minor_down ? minor_pos - COORD_BITS'(1) : minor_pos + COORD_BITS'(1);
      end
    end
  end

  // pixel address and clip
  logic signed [COORD_BITS-1:0] px, py;
  logic [EW-1:0]     w_eff, h_eff;
  logic [CMP_W-1:0]  xu, yu, wu, hu;
  logic [PROD_W-1:0] idx_full;
  logic              inside_c;
  always_comb begin
    px = major_is_x ? major_pos : minor_pos;
    py = major_is_x ? minor_pos : major_pos;
    w_eff = (EW'(frame_width) > MAX_DIM_V) ? MAX_DIM_V : EW'(frame_width);
    h_eff = (EW'(frame_height) > MAX_DIM_V) ? MAX_DIM_V : EW'(frame_height);
    xu = CMP_W'($unsigned(px));
    yu = CMP_W'($unsigned(py));
    wu = CMP_W'(w_eff);
    hu = CMP_W'(h_eff);
    inside_c = !px[COORD_BITS-1] && !py[COORD_BITS-1] && (xu < wu) && (yu < hu);
    idx_full = PROD_W'(yu) * PROD_W'(wu) + PROD_W'(xu);
  end

  logic [NUM_W-1:0] divisor;
  assign divisor = NUM_W'(line_len) << bit_cnt;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      calc_x      <= px;
      calc_y      <= py;
      calc_inside <= inside_c;
      calc_index  <= inside_c ? idx_full[blcr_pkg::INDEX_BITS-1:0] : '0;
      calc_last   <= step_i >= line_len;
      sel_from    <= (line_len == '0) || (step_i == '0);
      sel_to      <= step_i >= line_len;
      bit_cnt     <= BC_W'(COLOR_BITS - 1);
      for (int k = 0; k < 3; k++) begin
        rem[k]  <= NUM_W'(color_from[k]) * NUM_W'(line_len - step_i)
                 + NUM_W'(color_to[k]) * NUM_W'(step_i);
        quot[k] <= '0;
      end
    end else if (cmd.div_step) begin
      bit_cnt <= bit_cnt - BC_W'(1);
      for (int k = 0; k < 3; k++) begin
        if (rem[k] >= divisor) begin
          rem[k]           <= rem[k] - divisor;
          quot[k][bit_cnt] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pixel_x     <= calc_x;
      pixel_y     <= calc_y;
      pixel_index <= calc_index;
      inside_res  <= calc_inside;
      last        <= calc_last;
      for (int k = 0; k < 3; k++) begin
        rgb[k*COLOR_BITS +: COLOR_BITS] <= sel_from ? color_from[k] :
                                           sel_to   ? color_to[k] : quot[k];
      end
    end
  end

  assign sts.line_active = line_active;
  assign sts.div_last    = bit_cnt == '0;
endmodule
`default_nettype wire

// ----- hdl/blcr_checker.sv -----
// Port-level checks of the rasterizer and their binding.
`default_nettype none
`include "assert_macros.svh"
module blcr_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              in_func,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              out_inside,
  input wire logic [blcr_pkg::INDEX_BITS-1:0]   out_index
);
  `BLCR_ASSERT(a_hold_result, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")
  `BLCR_ASSERT(a_start_busy, clk, rst, in_valid && in_ready && in_func |=> !in_ready, "start not busy")
  `BLCR_ASSERT(a_clip_index, clk, rst, out_valid && !out_inside |-> out_index == '0, "clipped index")
  `BLCR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result after reset")
endmodule

bind bresenham_line_color_rasterizer blcr_checker u_blcr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix_in.valid),
  .in_ready   (pix_in.ready),
  .in_func    (pix_in.func),
  .out_valid  (pix_out.valid),
  .out_ready  (pix_out.ready),
  .out_inside (pix_out.inside_res),
  .out_index  (pix_out.pixel_index)
);
`default_nettype wire
